@@ rtl/ctic_pkg.sv @@
// ----------------------------------------------------------------------------
// ctic_pkg: shared types and constants of the callback target integrity check
// Sizes of the target table, the word formats of both channels and the
// register indexes of the configuration port.
// ----------------------------------------------------------------------------
package ctic_pkg;

  // Number of key/target pairs the table can hold.
  localparam int TABLE_ENTRIES = 64;
  // Number of low address bits that take part in matching and storage.
  localparam int ADDR_BITS     = 64;
  // Width of a table index.
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  // One table row holds a key and its target.
  localparam int ROW_W         = 2 * ADDR_BITS;

  localparam int FIELD_W       = 64;
  localparam int CNT_W         = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT_MODE  = CFG_IDX_W'(1);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic [FIELD_W-1:0] source_key;
    logic [FIELD_W-1:0] target_addr;
  } in_word_t;

  typedef struct packed {
    logic               allow_dispatch;
    logic               newly_registered;
    logic               target_changed;
    logic               target_unknown;
    logic               table_full;
    logic [CNT_W-1:0]   violation_total;
    logic [CNT_W-1:0]   call_total;
  } out_word_t;

  // Per-dispatch verdict passed from the table controller to the top level.
  typedef struct packed {
    logic allow_dispatch;
    logic newly_registered;
    logic target_changed;
    logic target_unknown;
    logic table_full;
  } verdict_t;

  // Saturating increment of an event counter.
  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : cnt_t'(v + cnt_t'(1));
  endfunction

endpackage

@@ rtl/ctic_ram.sv @@
// ----------------------------------------------------------------------------
// ctic_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ctic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ctic_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctic_ctrl: table controller
// Takes one dispatch, sweeps the key/target RAM once if checking is on and the
// key nonzero, for the matching key, lowest free entry and whether the target
// is stored, registers the pair if new and hands a verdict to the top level.
// ----------------------------------------------------------------------------
module ctic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ctic_pkg::addr_t   in_key,
  input  ctic_pkg::addr_t   in_tgt,
  input  logic              check_enable,
  input  logic              strict_mode,
  output logic              res_valid,
  input  logic              res_ready,
  output ctic_pkg::verdict_t res_verdict
);
  import ctic_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TAIL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  addr_t key_r, tgt_r;
  logic  active_r;
  idx_t  scan_r, scan_nxt;
  logic  cmp_en_r;
  idx_t  cmp_idx_r;
  logic  hit_r, known_r, free_found_r;
  addr_t hit_tgt_r;
  idx_t  free_idx_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [ROW_W-1:0] rd_row;
  addr_t            rd_key, rd_tgt;
  logic             accept;
  logic             ram_we;
  verdict_t         verdict;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign rd_key   = rd_row[ROW_W-1:ADDR_BITS];
  assign rd_tgt   = rd_row[ADDR_BITS-1:0];

  // Verdict from the sweep results.
  always_comb begin
    verdict = '0;
    verdict.allow_dispatch = 1'b1;
    if (active_r) begin
      if (!hit_r) begin
        if (tgt_r != '0) begin
          verdict.newly_registered = free_found_r;
          verdict.table_full       = !free_found_r;
        end
      end else if (tgt_r != '0 && tgt_r != hit_tgt_r) begin
        verdict.target_changed = 1'b1;
        verdict.target_unknown = !known_r;
        verdict.allow_dispatch = !(!known_r && strict_mode);
      end
    end
  end

  assign res_valid   = (state_r == S_DONE) && res_ready;
  assign res_verdict = verdict;
  assign ram_we      = res_valid && verdict.newly_registered;

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    unique case (state_r)
      S_IDLE: begin
        scan_nxt = '0;
        if (accept) begin
          state_nxt = (check_enable && in_key != '0) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        scan_nxt = idx_t'(scan_r + idx_t'(1));
        if (scan_r == idx_t'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cmp_en_r <= 1'b0;
      valid_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      cmp_en_r <= (state_r == S_SCAN);
      if (ram_we) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  // Sweep bookkeeping; the read issued last cycle is judged this cycle.
  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    cmp_idx_r <= scan_r;
    if (accept) begin
      key_r        <= in_key;
      tgt_r        <= in_tgt;
      active_r     <= check_enable && (in_key != '0);
      hit_r        <= 1'b0;
      known_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmp_en_r) begin
      if (valid_r[cmp_idx_r]) begin
        if (!hit_r && rd_key == key_r) begin
          hit_r     <= 1'b1;
          hit_tgt_r <= rd_tgt;
        end
        if (rd_tgt == tgt_r) begin
          known_r <= 1'b1;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
    end
  end

  ctic_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata ({key_r, tgt_r}),
    .raddr (scan_r),
    .rdata (rd_row)
  );

  // A verdict never claims both a registration and a full table.
  a_reg_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(res_verdict.newly_registered && res_verdict.table_full))
    else $error("registration and table full in one verdict");

  // An unknown target is only reported together with a changed target.
  a_unknown_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_verdict.target_unknown) |-> res_verdict.target_changed)
    else $error("unknown target without a change");

  // A registration marks its entry valid on the next cycle.
  a_reg_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_verdict.newly_registered) |=> valid_r[$past(free_idx_r)])
    else $error("registered entry not marked valid");

endmodule

@@ rtl/callback_target_integrity_check_core.sv @@
// ----------------------------------------------------------------------------
// callback_target_integrity_check_core: callback target integrity checker
// Tracks the first target seen for each dispatching key, flags changed and
// unknown targets, and counts dispatches and violations.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Word
//  --------  ---------  -------------------  -------------------------------
//  in_       input      in_valid/in_stall    source_key, target_addr
//  out_      output     out_valid/out_stall  verdict flags and both counters
//  cfg_      input      cfg_we               cfg_index selects, cfg_wdata bit 0
//
// A checked dispatch is accepted, sweeps the key/target RAM at one entry per
// cycle, judges the last read in a tail state and writes back and issues the
// verdict in a done state; with checking off or a zero key it goes from accept
// straight to done. Synchronous active-low reset clears the valid bits, the
// counters, state and strict mode, sets checking on, with no pass over the RAM.
// A stalled output holds the controller only once its next verdict is ready.
// ----------------------------------------------------------------------------
module callback_target_integrity_check_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ctic_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ctic_pkg::out_word_t                out_data,
  input  logic                               cfg_we,
  input  logic [ctic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctic_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ctic_pkg::*;

  // Configuration registers.
  logic check_enable_r;
  logic strict_mode_r;

  // Saturating event counters.
  cnt_t call_cnt_r, call_cnt_nxt;
  cnt_t vio_cnt_r,  vio_cnt_nxt;

  // Output register.
  logic      out_valid_r;
  out_word_t out_data_r;

  logic      res_valid;
  logic      res_ready;
  verdict_t  res_verdict;

  // The output register can take a verdict when empty or being drained.
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_enable_r <= 1'b1;
      strict_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHECK_ENABLE: check_enable_r <= cfg_wdata[0];
        CFG_STRICT_MODE:  strict_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Every dispatch counts as a call; only changed targets count as violations.
  always_comb begin
    call_cnt_nxt = sat_inc(call_cnt_r);
    vio_cnt_nxt  = res_verdict.target_changed ? sat_inc(vio_cnt_r) : vio_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      call_cnt_r  <= '0;
      vio_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid) begin
        call_cnt_r  <= call_cnt_nxt;
        vio_cnt_r   <= vio_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r.allow_dispatch   <= res_verdict.allow_dispatch;
      out_data_r.newly_registered <= res_verdict.newly_registered;
      out_data_r.target_changed   <= res_verdict.target_changed;
      out_data_r.target_unknown   <= res_verdict.target_unknown;
      out_data_r.table_full       <= res_verdict.table_full;
      out_data_r.violation_total  <= vio_cnt_nxt;
      out_data_r.call_total       <= call_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only the low ADDR_BITS bits of an address take part in the check.
  ctic_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_key       (in_data.source_key[ADDR_BITS-1:0]),
    .in_tgt       (in_data.target_addr[ADDR_BITS-1:0]),
    .check_enable (check_enable_r),
    .strict_mode  (strict_mode_r),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_verdict  (res_verdict)
  );

  // The call counter never moves backward outside reset.
  a_call_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (call_cnt_r >= $past(call_cnt_r)))
    else $error("call counter decreased");

  // The violation counter never passes the call counter.
  a_vio_le_call: assert property (@(posedge clk) disable iff (!rst_n)
    vio_cnt_r <= call_cnt_r)
    else $error("more violations than calls");

  // A stalled verdict word stays in place until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled verdict word changed");

endmodule

@@ dv/callback_target_integrity_check_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// callback_target_integrity_check_core_test: self-checking bench of the checker
// Runs a short directed table of dispatches and register writes and then a long
// random run under varied idling. Every verdict word is checked against an
// in-bench predictor of the table and both counters, or a hand-written verdict.
// ----------------------------------------------------------------------------
module callback_target_integrity_check_core_test;
  import ctic_pkg::*;

  // Register indexes past the end of the register list. Writes to them must
  // leave the checker unchanged.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  localparam addr_t ALL_ONES   = '1;
  localparam int    KEY_POOL   = 96;
  localparam int    TGT_POOL   = 12;
  localparam int    HOLD_LEN   = 500;
  localparam int    CYCLE_CAP  = 1000000;

  // Random phases. The first and the last run with no idling at all; the last
  // one also opens with a long receiver hold-off.
  localparam int PH_IDLE   [5] = '{0, 48, 0, 11, 0};
  localparam int PH_STALL  [5] = '{0, 0, 48, 11, 0};
  localparam int PH_CHECK  [5] = '{1, 1, 0, 1, 1};
  localparam int PH_STRICT [5] = '{0, 1, 1, 1, 0};
  localparam int PH_ITEMS  [5] = '{320, 300, 200, 320, 320};

  typedef enum logic {ROW_DISPATCH, ROW_WRITE} row_kind_t;

  // One row of the directed table: either a register write or a dispatch word,
  // the latter optionally with its verdict written out by hand.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic                   reg_val;
    logic                   fixed_want;
    in_word_t               word;
    out_word_t              want;
  } row_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  in_word_t                in_data   = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_word_t               out_data;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  // Predictor state: the dispatch table, both counters and the registers.
  addr_t      seen_key    [TABLE_ENTRIES];
  addr_t      seen_target [TABLE_ENTRIES];
  bit         slot_used   [TABLE_ENTRIES];
  cnt_t       model_violations = '0;
  cnt_t       model_calls      = '0;
  bit         model_check_en   = 1'b1;
  bit         model_strict     = 1'b0;

  // Verdicts predicted for accepted words, oldest first.
  out_word_t  pending_verdicts [$];

  addr_t      key_pool    [KEY_POOL];
  addr_t      target_pool [TGT_POOL];
  row_t       directed_plan [$];

  int         idle_pct   = 0;
  int         stall_pct  = 0;
  logic       long_hold  = 1'b0;
  int         cycle_count = 0;
  bit         failed     = 1'b0;

  callback_target_integrity_check_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver. It stalls at random with the current percentage. While a long
  // hold-off is requested it keeps the output stalled until the hold-off count
  // kept here runs out, so the checker backs up and stalls its input.
  always @(posedge clk) begin : receiver
    int hold_cycles;
    if (long_hold && hold_cycles < HOLD_LEN) begin
      hold_cycles++;
      out_stall <= 1'b1;
    end else begin
      if (!long_hold) hold_cycles = 0;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Predict the verdict of one dispatch and advance the predictor state. A
  // lookup only ever compares entries that are in use, so unwritten entries
  // are never read.
  function automatic out_word_t judge_dispatch(input in_word_t w);
    addr_t     key;
    addr_t     tgt;
    int        hit;
    int        free_slot;
    bit        known;
    out_word_t v;
    key = addr_t'(w.source_key);
    tgt = addr_t'(w.target_addr);
    v = '0;
    v.allow_dispatch = 1'b1;
    if (model_calls != '1) model_calls++;
    if (model_check_en && key != '0) begin
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_used[i]) begin
          if (hit < 0 && seen_key[i] == key) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit < 0) begin
        // A new key is registered only with a real target, in the lowest
        // free entry, or reported as not fitting.
        if (tgt != '0) begin
          if (free_slot >= 0) begin
            seen_key[free_slot]    = key;
            seen_target[free_slot] = tgt;
            slot_used[free_slot]   = 1'b1;
            v.newly_registered     = 1'b1;
          end else begin
            v.table_full = 1'b1;
          end
        end
      end else if (tgt != '0 && tgt != seen_target[hit]) begin
        // A changed target is a violation; it is unknown when no entry in
        // use holds it as its target.
        v.target_changed = 1'b1;
        if (model_violations != '1) model_violations++;
        known = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_used[i] && seen_target[i] == tgt) known = 1'b1;
        v.target_unknown = !known;
        if (!known && model_strict) v.allow_dispatch = 1'b0;
      end
    end
    v.violation_total = model_violations;
    v.call_total      = model_calls;
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Result checker: every accepted verdict word is matched against the
  // oldest prediction, field by field.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict word, expected none, actual %h", $time, out_data);
        failed = 1'b1;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("allow_dispatch", CNT_W'(want.allow_dispatch), CNT_W'(out_data.allow_dispatch));
        check_field("newly_registered", CNT_W'(want.newly_registered),
                    CNT_W'(out_data.newly_registered));
        check_field("target_changed", CNT_W'(want.target_changed), CNT_W'(out_data.target_changed));
        check_field("target_unknown", CNT_W'(want.target_unknown), CNT_W'(out_data.target_unknown));
        check_field("table_full", CNT_W'(want.table_full), CNT_W'(out_data.table_full));
        check_field("violation_total", want.violation_total, out_data.violation_total);
        check_field("call_total", want.call_total, out_data.call_total);
      end
    end
  end

  // Offer one dispatch word and hold it until it is taken. The prediction is
  // made at the accepting edge; a hand-written verdict replaces it where the
  // directed table gives one. Afterwards the sender idles at random.
  task automatic offer_dispatch(input in_word_t w, input logic fixed_want,
                                input out_word_t want);
    out_word_t predicted;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predicted = judge_dispatch(w);
    pending_verdicts.push_back(fixed_want ? want : predicted);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted verdict has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // One register write. The predictor takes the value at the same edge as
  // the checker; indexes past the list change nothing.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CHECK_ENABLE: model_check_en = val;
      CFG_STRICT_MODE:  model_strict   = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic row_t plan_write(input logic [CFG_IDX_W-1:0] idx, input logic val);
    row_t r;
    r = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic row_t plan_call(input addr_t key, input addr_t tgt);
    row_t r;
    r = '0;
    r.kind = ROW_DISPATCH;
    r.word = {key, tgt};
    return r;
  endfunction

  // Flags are given as {allow, registered, changed, unknown, full}.
  function automatic row_t plan_known(input addr_t key, input addr_t tgt,
                                      input logic [4:0] flags, input cnt_t viol,
                                      input cnt_t calls);
    row_t r;
    r = plan_call(key, tgt);
    r.fixed_want = 1'b1;
    r.want = out_word_t'({flags, viol, calls});
    return r;
  endfunction

  // Random dispatch. Keys mostly come from a pool somewhat larger than the
  // table, so that hits are frequent and the table fills up. Targets mostly
  // come from a small pool, with a preferred target per key, so that repeated
  // targets, known changed targets and unknown ones all occur.
  function automatic in_word_t random_dispatch();
    int unsigned ki;
    int unsigned roll;
    in_word_t    w;
    ki = $urandom_range(KEY_POOL - 1);
    roll = $urandom_range(99);
    if (roll < 5)       w.source_key = '0;
    else if (roll < 12) w.source_key = {$urandom, $urandom};
    else                w.source_key = key_pool[ki];
    roll = $urandom_range(99);
    if (roll < 8)       w.target_addr = '0;
    else if (roll < 20) w.target_addr = {$urandom, $urandom};
    else if (roll < 65) w.target_addr = target_pool[ki % TGT_POOL];
    else                w.target_addr = target_pool[$urandom_range(TGT_POOL - 1)];
    return w;
  endfunction

  initial begin : stimulus
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    foreach (target_pool[i]) target_pool[i] = {$urandom, $urandom};

    // Directed table. Right after reset checking is on and strict mode off.
    // A zero key is passed through, a zero target on a new key registers
    // nothing, then one key is registered and revisited with the same, a
    // changed unknown, a changed known and a zero target.
    directed_plan.push_back(plan_known('0, ALL_ONES, 5'b10000, 0, 1));
    directed_plan.push_back(plan_known(ALL_ONES, '0, 5'b10000, 0, 2));
    directed_plan.push_back(plan_known(ALL_ONES, ALL_ONES, 5'b11000, 0, 3));
    directed_plan.push_back(plan_known(ALL_ONES, ALL_ONES, 5'b10000, 0, 4));
    directed_plan.push_back(plan_known(ALL_ONES, 64'h1, 5'b10110, 1, 5));
    directed_plan.push_back(plan_known(64'h1, 64'h1, 5'b11000, 1, 6));
    directed_plan.push_back(plan_known(ALL_ONES, 64'h1, 5'b10100, 2, 7));
    directed_plan.push_back(plan_known(ALL_ONES, '0, 5'b10000, 2, 8));
    directed_plan.push_back(plan_known(64'h1, ALL_ONES, 5'b10100, 3, 9));
    // Strict mode blocks only unknown changed targets.
    directed_plan.push_back(plan_write(CFG_STRICT_MODE, 1'b1));
    directed_plan.push_back(plan_known(64'h1, 64'h5555_5555_5555_5555, 5'b00110, 4, 10));
    directed_plan.push_back(plan_call(ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA));
    directed_plan.push_back(plan_known('0, '0, 5'b10000, 5, 12));
    // Writes past the register list are ignored.
    directed_plan.push_back(plan_write(CFG_SPARE_LO, 1'b1));
    directed_plan.push_back(plan_write(CFG_SPARE_HI, 1'b0));
    // With checking off everything passes and nothing is registered.
    directed_plan.push_back(plan_write(CFG_CHECK_ENABLE, 1'b0));
    directed_plan.push_back(plan_known(64'h1, 64'hAAAA_AAAA_AAAA_AAAA, 5'b10000, 5, 13));
    directed_plan.push_back(plan_known(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                                       5'b10000, 5, 14));
    directed_plan.push_back(plan_write(CFG_CHECK_ENABLE, 1'b1));
    directed_plan.push_back(plan_call(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000));
    directed_plan.push_back(plan_call(64'h1, 64'h8000_0000_0000_0000));
    directed_plan.push_back(plan_call(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE));
    directed_plan.push_back(plan_write(CFG_STRICT_MODE, 1'b0));
    directed_plan.push_back(plan_call(64'h7FFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF));
    directed_plan.push_back(plan_call(64'hFEDC_BA98_7654_3210, 64'h7FFF_FFFF_FFFF_FFFF));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_WRITE) begin
        settle();
        write_reg(directed_plan[r].reg_idx, directed_plan[r].reg_val);
      end else begin
        offer_dispatch(directed_plan[r].word, directed_plan[r].fixed_want,
                       directed_plan[r].want);
      end
    end

    // Random phases. Each one starts from an idle checker, so the registers
    // are rewritten only once all verdicts of the previous phase are in.
    for (int p = 0; p < 5; p++) begin
      settle();
      write_reg(CFG_CHECK_ENABLE, PH_CHECK[p][0]);
      write_reg(CFG_STRICT_MODE, PH_STRICT[p][0]);
      idle_pct = PH_IDLE[p];
      stall_pct <= PH_STALL[p];
      if (p == 4) begin
        // Keep offering words through a long hold-off; the checker fills up
        // and stalls its input until the receiver lets go.
        long_hold <= 1'b1;
        repeat (12) offer_dispatch(random_dispatch(), 1'b0, '0);
        long_hold <= 1'b0;
      end
      repeat (PH_ITEMS[p]) offer_dispatch(random_dispatch(), 1'b0, '0);
    end

    settle();
    repeat (4 * (TABLE_ENTRIES + 3)) @(posedge clk);
    if (failed) begin
      $display("FAILED: results differ");
    end else begin
      $display("PASSED: all results match");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ctic_pkg.sv
rtl/ctic_ram.sv
rtl/ctic_ctrl.sv
rtl/callback_target_integrity_check_core.sv
dv/callback_target_integrity_check_core_test.sv
